FILE: design/egd_pkg.sv
// Package for the elevator group dispatcher: types, codes and defaults.
`default_nettype none
package egd_pkg;
   localparam int DEF_NUM_CARS   = 4;
   localparam int DEF_NUM_FLOORS = 16;
   localparam int MAX_REPORT     = 4;

   localparam logic [1:0] OP_HALL = 2'd0;
   localparam logic [1:0] OP_CAR  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] HEAD_UP   = 2'd0;
   localparam logic [1:0] HEAD_DOWN = 2'd1;
   localparam logic [1:0] HEAD_IDLE = 2'd2;

   localparam logic CSR_STRATEGY    = 1'b0;
   localparam logic CSR_CARS_IN_USE = 1'b1;

   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] floor;
      logic       call_direction;
      logic [1:0] car;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [1:0] car_index;
      logic [3:0] car_floor;
      logic [1:0] car_direction;
      logic       door_open;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: design/elevator_group_dispatcher_unit.sv
// Elevator group dispatcher: hall/car call assignment and per-car LOOK movement.
//  channel | ports                          | dir | content
//  req     | req_valid req_ready req_data   | in  | operation, floor, direction, car
//  rsp     | rsp_valid rsp_ready rsp_data   | out | assignment or car status
//  csr     | csr_we csr_index csr_wdata     | in  | strategy, cars_in_use
// A hall call walks the cars in use one per cycle through one shared compare
// unit, then updates the chosen car.
// A tick runs an update step for every car in turn, and a send step for each of
// the first MAX_REPORT cars; the others are silent. req_ready is low meanwhile.
// Reset is synchronous and clears all car state; one request at a time.
// A waiting result holds the unit in its send state until rsp_ready is high.
`default_nettype none
module elevator_group_dispatcher_unit
   import egd_pkg::*;
#(
   parameter int NUM_CARS   = DEF_NUM_CARS,
   parameter int NUM_FLOORS = DEF_NUM_FLOORS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic [2:0] csr_wdata
);
   localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
   localparam int FW = $clog2(NUM_FLOORS);
   localparam int LW = $clog2(2 * NUM_FLOORS + 1);
   localparam int NREP = (NUM_CARS < MAX_REPORT) ? NUM_CARS : MAX_REPORT;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ADD, S_TICK, S_SEND} state_type;

   state_type state_ff;
   logic strategy_ff;
   logic [2:0] cars_in_use_ff;
   logic [FW-1:0] pos_ff [NUM_CARS];
   logic [FW-1:0] tgt_ff [NUM_CARS];
   logic [1:0] head_ff [NUM_CARS];
   logic [NUM_FLOORS-1:0] up_ff [NUM_CARS];
   logic [NUM_FLOORS-1:0] dn_ff [NUM_CARS];
   logic dphase_ff [NUM_CARS];
   logic trav_ff [NUM_CARS];

   req_type req_ff;
   logic [FW-1:0] fl_ff;
   logic [CW-1:0] idx_ff, best_ff, idle_ff;
   logic found_ff, idle_found_ff, tick_ff;
   logic [LW-1:0] score_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   // saturated floor and active car count
   logic [FW-1:0] fl_sat;
   always_comb begin
      if (32'(req_data.floor) >= NUM_FLOORS) fl_sat = FW'(NUM_FLOORS - 1);
      else fl_sat = FW'(req_data.floor);
   end
   logic [3:0] n_act;
   always_comb begin
      n_act = {1'b0, cars_in_use_ff};
      if (n_act == 4'd0) n_act = 4'd1;
      if (32'(n_act) > NUM_CARS) n_act = 4'(NUM_CARS);
   end

   // shared scan unit, looks at car idx_ff
   logic [FW-1:0] t;
   logic [LW-1:0] cand;
   logic ok;
   always_comb begin
      t = tgt_ff[idx_ff];
      ok = 1'b1;
      if (strategy_ff) begin
         cand = LW'($countones(up_ff[idx_ff])) + LW'($countones(dn_ff[idx_ff]));
      end else begin
         cand = (t >= fl_ff) ? LW'(t - fl_ff) : LW'(fl_ff - t);
         ok = (head_ff[idx_ff] == {1'b0, req_ff.call_direction}) &&
              ((!req_ff.call_direction && t <= fl_ff) ||
               (req_ff.call_direction && t >= fl_ff));
      end
   end

   // tick unit for car idx_ff
   logic [NUM_FLOORS-1:0] u_c, d_c;
   logic ph_c, tr_c, door_c;
   logic [FW-1:0] tg_c, ps_c, lo_c, hi_c;
   logic [1:0] hd_c;
   always_comb begin
      u_c = up_ff[idx_ff]; d_c = dn_ff[idx_ff];
      ph_c = dphase_ff[idx_ff]; tr_c = trav_ff[idx_ff];
      tg_c = tgt_ff[idx_ff]; ps_c = pos_ff[idx_ff]; hd_c = head_ff[idx_ff];
      door_c = 1'b0;
      lo_c = '0; hi_c = '0;
      for (int i = NUM_FLOORS - 1; i >= 0; i--) if (u_c[i]) lo_c = FW'(i);
      for (int i = 0; i < NUM_FLOORS; i++) if (d_c[i]) hi_c = FW'(i);
      if (!tr_c) begin
         if (u_c == '0 && d_c == '0) begin
            hd_c = HEAD_IDLE;
         end else begin
            if (!ph_c && u_c == '0) ph_c = 1'b1;
            else if (ph_c && d_c == '0) ph_c = 1'b0;
            if (ph_c) begin
               tg_c = hi_c; d_c[hi_c] = 1'b0;
            end else begin
               tg_c = lo_c; u_c[lo_c] = 1'b0;
            end
            tr_c = 1'b1;
         end
      end
      if (tr_c) begin
         if (ps_c == tg_c) begin
            tr_c = 1'b0; door_c = 1'b1;
         end else begin
            if (tg_c > ps_c) begin
               hd_c = HEAD_UP; ps_c = ps_c + 1'b1;
            end else begin
               hd_c = HEAD_DOWN; ps_c = ps_c - 1'b1;
            end
            if (ps_c == tg_c) begin
               tr_c = 1'b0; door_c = 1'b1;
            end
         end
      end
   end

   // car chosen for the add step
   logic [CW-1:0] sel;
   always_comb begin
      if (req_ff.operation == OP_CAR) sel = CW'(req_ff.car);
      else if (found_ff) sel = best_ff;
      else if (idle_found_ff) sel = idle_ff;
      else sel = '0;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         strategy_ff <= 1'b0;
         cars_in_use_ff <= 3'd4;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CARS; c++) begin
            pos_ff[c] <= '0; tgt_ff[c] <= '0; head_ff[c] <= HEAD_IDLE;
            up_ff[c] <= '0; dn_ff[c] <= '0; dphase_ff[c] <= 1'b0; trav_ff[c] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_STRATEGY) strategy_ff <= csr_wdata[0];
            else cars_in_use_ff <= csr_wdata;
         end
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               fl_ff <= fl_sat;
               idx_ff <= '0;
               found_ff <= 1'b0;
               idle_found_ff <= 1'b0;
               score_ff <= '1;
               best_ff <= '0;
               idle_ff <= '0;
               unique case (req_data.operation)
                  OP_HALL: state_ff <= S_SCAN;
                  OP_CAR: if (32'(req_data.car) < NUM_CARS) state_ff <= S_ADD;
                  OP_TICK: state_ff <= S_TICK;
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_SCAN: begin
               if (ok && cand < score_ff) begin
                  score_ff <= cand; best_ff <= idx_ff; found_ff <= 1'b1;
               end
               if (!strategy_ff && !idle_found_ff && head_ff[idx_ff] == HEAD_IDLE) begin
                  idle_found_ff <= 1'b1; idle_ff <= idx_ff;
               end
               if (32'(idx_ff) + 1 >= 32'(n_act)) state_ff <= S_ADD;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_ADD: begin
               if (fl_ff != tgt_ff[sel]) begin
                  if (fl_ff >= tgt_ff[sel]) up_ff[sel][fl_ff] <= 1'b1;
                  else dn_ff[sel][fl_ff] <= 1'b1;
               end
               rsp_ff <= '{KIND_ASSIGN, 2'(sel), 4'(fl_ff), head_ff[sel], 1'b0, 1'b1};
               rsp_valid_ff <= 1'b1;
               tick_ff <= 1'b0;
               state_ff <= S_SEND;
            end
            S_TICK: begin
               up_ff[idx_ff] <= u_c; dn_ff[idx_ff] <= d_c;
               dphase_ff[idx_ff] <= ph_c; trav_ff[idx_ff] <= tr_c;
               tgt_ff[idx_ff] <= tg_c; pos_ff[idx_ff] <= ps_c; head_ff[idx_ff] <= hd_c;
               tick_ff <= 1'b1;
               if (32'(idx_ff) < NREP) begin
                  rsp_ff <= '{KIND_STATUS, 2'(idx_ff), 4'(ps_c), hd_c, door_c,
                              32'(idx_ff) + 1 == NREP};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_SEND;
               end else if (32'(idx_ff) + 1 >= NUM_CARS) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_SEND: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               if (tick_ff && 32'(idx_ff) + 1 < NUM_CARS) begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_TICK;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_SEND) else $error("rsp_valid outside send");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_assign_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_ASSIGN |-> rsp_data.last && !rsp_data.door_open)
      else $error("bad assignment result");
endmodule
`default_nettype wire
